// ===== rtl/swks_pkg.sv =====
package swks_pkg;

  localparam int unsigned WINDOW_MAX_DEF  = 32;
  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned CFG_BITS        = 6;
  localparam int unsigned CFG_IDX_BITS    = 1;
  localparam int unsigned SUM_BITS        = 48;

  localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_LEN = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_RANK_K     = 1'b1;

  localparam logic [CFG_BITS-1:0] WINDOW_LEN_RST = 6'd8;
  localparam logic [CFG_BITS-1:0] RANK_K_RST     = 6'd1;

  // one command word broadcast along the row of cells
  typedef struct packed {
    logic shift;    // new sample enters at cell 0
    logic load;     // copy held value into the rotating lane, clear counters
    logic count;    // compare against the passing value, rotate the ring
    logic mark;     // load the collect lane with the selected value
    logic collect;  // OR-shift the collect lane towards cell 0
  } cell_cmd_t;

endpackage

// ===== rtl/sliding_window_kth_largest_sum.sv =====
// A beat that leaves the window short of full is taken with no result; ready stays high.
// A beat that fills it gives a result after the load, count, mark, collect and out
// states (out waits while an earlier result is stalled); no new beat is taken meanwhile,
// the work set by the ring of cells: one rotation to rank every value, one pass to collect it.
// Reset (async, active low) empties the window, clears the sum, loads length 8
// and rank 1; no clearing pass.
module sliding_window_kth_largest_sum #(
  parameter int unsigned WINDOW_MAX  = swks_pkg::WINDOW_MAX_DEF,
  parameter int unsigned SAMPLE_BITS = swks_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [swks_pkg::CFG_IDX_BITS-1:0]      cfg_idx_i,
  input  logic [swks_pkg::CFG_BITS-1:0]          cfg_data_i,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // sample
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_axis_tdata,
  // start_req
  input  logic                                   s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // kth_value, total_sum
  output logic [((SAMPLE_BITS+swks_pkg::SUM_BITS+7)/8)*8-1:0] m_axis_tdata
);

  localparam int unsigned CNT_BITS = $clog2(WINDOW_MAX + 1);
  localparam int unsigned SUM_BITS = swks_pkg::SUM_BITS;
  localparam int unsigned OUT_W    = ((SAMPLE_BITS + SUM_BITS + 7) / 8) * 8;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_COUNT,
    S_MARK,
    S_COLLECT,
    S_OUT
  } state_e;

  localparam logic signed [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
  localparam logic signed [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

  logic [swks_pkg::CFG_BITS-1:0] cfg_len_q, cfg_rank_q;
  logic [CNT_BITS-1:0]           len_eff, rank_eff;

  state_e                        state_q, state_d;
  logic [CNT_BITS-1:0]           cnt_q, cnt_d;
  logic [CNT_BITS-1:0]           fill_q, fill_d;
  logic signed [SUM_BITS-1:0]    sum_acc_q, sum_acc_d;
  logic                          m_valid_q, m_valid_d;
  logic signed [SAMPLE_BITS-1:0] kth_q, kth_d;
  logic signed [SUM_BITS-1:0]    sum_out_q, sum_out_d;

  logic                          accept;
  logic                          start;
  logic [CNT_BITS-1:0]           fill_next;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic signed [SAMPLE_BITS-1:0] kth;
  logic signed [SUM_BITS:0]      sum_ext;
  logic signed [SUM_BITS-1:0]    sum_sat;
  swks_pkg::cell_cmd_t           cmd;

  logic signed [SAMPLE_BITS-1:0] value_w [WINDOW_MAX];
  logic signed [SAMPLE_BITS-1:0] rot_w   [WINDOW_MAX];
  logic [SAMPLE_BITS-1:0]        col_w   [WINDOW_MAX];
  logic [WINDOW_MAX-1:0]         hit_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_len_q  <= swks_pkg::WINDOW_LEN_RST;
      cfg_rank_q <= swks_pkg::RANK_K_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        swks_pkg::REG_WINDOW_LEN: cfg_len_q  <= cfg_data_i;
        swks_pkg::REG_RANK_K:     cfg_rank_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    len_eff = CNT_BITS'(cfg_len_q);
    if (cfg_len_q == '0) begin
      len_eff = CNT_BITS'(1);
    end else if (int'(cfg_len_q) > int'(WINDOW_MAX)) begin
      len_eff = CNT_BITS'(WINDOW_MAX);
    end
    rank_eff = CNT_BITS'(cfg_rank_q);
    if (cfg_rank_q == '0) begin
      rank_eff = CNT_BITS'(1);
    end else if (int'(cfg_rank_q) > int'(len_eff)) begin
      rank_eff = len_eff;
    end
  end

  assign sample        = s_axis_tdata[SAMPLE_BITS-1:0];
  assign start         = s_axis_tuser;
  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    if (start) begin
      fill_next = CNT_BITS'(1);
    end else if (int'(fill_q) < int'(WINDOW_MAX)) begin
      fill_next = fill_q + 1'b1;
    end else begin
      fill_next = fill_q;
    end
  end

  assign kth     = col_w[0];
  assign sum_ext = (SUM_BITS+1)'(sum_acc_q) + (SUM_BITS+1)'(kth);
  always_comb begin
    sum_sat = sum_ext[SUM_BITS-1:0];
    if (sum_ext[SUM_BITS] != sum_ext[SUM_BITS-1]) begin
      sum_sat = sum_ext[SUM_BITS] ? SUM_MIN : SUM_MAX;
    end
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    fill_d    = fill_q;
    sum_acc_d = sum_acc_q;
    m_valid_d = m_valid_q;
    kth_d     = kth_q;
    sum_out_d = sum_out_q;
    cmd       = '0;
    if (m_axis_tvalid && m_axis_tready) begin
      m_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd.shift = 1'b1;
          fill_d    = fill_next;
          if (start) begin
            sum_acc_d = '0;
          end
          if (fill_next >= len_eff) begin
            state_d = S_LOAD;
          end
        end
      end
      S_LOAD: begin
        cmd.load = 1'b1;
        cnt_d    = '0;
        state_d  = S_COUNT;
      end
      S_COUNT: begin
        cmd.count = 1'b1;
        cnt_d     = cnt_q + 1'b1;
        if (cnt_q == len_eff - 1'b1) begin
          state_d = S_MARK;
        end
      end
      S_MARK: begin
        cmd.mark = 1'b1;
        cnt_d    = '0;
        state_d  = S_COLLECT;
      end
      S_COLLECT: begin
        cmd.collect = 1'b1;
        cnt_d       = cnt_q + 1'b1;
        if (cnt_q == len_eff - 1'b1) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          kth_d     = kth;
          sum_out_d = sum_sat;
          sum_acc_d = sum_sat;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      fill_q    <= '0;
      sum_acc_q <= '0;
      m_valid_q <= 1'b0;
      kth_q     <= '0;
      sum_out_q <= '0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      fill_q    <= fill_d;
      sum_acc_q <= sum_acc_d;
      m_valid_q <= m_valid_d;
      kth_q     <= kth_d;
      sum_out_q <= sum_out_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OUT_W'({sum_out_q, kth_q});

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic signed [SAMPLE_BITS-1:0] rot_next;
    logic [SAMPLE_BITS-1:0]        col_next;

    if (i == 0) begin : g_head
      assign sample_in = sample;
    end else begin : g_body
      assign sample_in = value_w[i-1];
    end
    if (i == WINDOW_MAX - 1) begin : g_tail
      assign rot_next = rot_w[0];
      assign col_next = '0;
    end else begin : g_link
      assign rot_next = rot_w[i+1];
      assign col_next = col_w[i+1];
    end

    swks_cell #(
      .INDEX       (i),
      .SAMPLE_BITS (SAMPLE_BITS),
      .CNT_BITS    (CNT_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .cmd_i      (cmd),
      .len_i      (len_eff),
      .rank_i     (rank_eff),
      .sample_i   (sample_in),
      .rot_next_i (rot_next),
      .rot_wrap_i (rot_w[0]),
      .col_next_i (col_next),
      .value_o    (value_w[i]),
      .rot_o      (rot_w[i]),
      .col_o      (col_w[i]),
      .hit_o      (hit_w[i])
    );
  end

  // after a full rotation at least one cell must hold the ranked value
  a_hit_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MARK |-> hit_w != '0)
    else $error("no cell selected after ranking");

  a_valid_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == S_OUT))
    else $error("result raised outside output state");

  a_short_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (fill_next < len_eff)) |=> state_q == S_IDLE && m_valid_q == $past(m_valid_d))
    else $error("beat short of a full window started ranking");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(fill_q) <= int'(WINDOW_MAX))
    else $error("fill count beyond window depth");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && m_valid_q && !m_axis_tready) |=> state_q == S_OUT)
    else $error("result overwritten while stalled");

endmodule

// ===== rtl/swks_cell.sv =====
module swks_cell #(
  parameter int unsigned INDEX       = 0,
  parameter int unsigned SAMPLE_BITS = swks_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned CNT_BITS    = 6
) (
  input  logic                          clk_i,
  input  swks_pkg::cell_cmd_t           cmd_i,
  input  logic [CNT_BITS-1:0]           len_i,
  input  logic [CNT_BITS-1:0]           rank_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic signed [SAMPLE_BITS-1:0] rot_next_i,
  input  logic signed [SAMPLE_BITS-1:0] rot_wrap_i,
  input  logic [SAMPLE_BITS-1:0]        col_next_i,
  output logic signed [SAMPLE_BITS-1:0] value_o,
  output logic signed [SAMPLE_BITS-1:0] rot_o,
  output logic [SAMPLE_BITS-1:0]        col_o,
  output logic                          hit_o
);

  logic signed [SAMPLE_BITS-1:0] value_q, value_d;
  logic signed [SAMPLE_BITS-1:0] rot_q, rot_d;
  logic [SAMPLE_BITS-1:0]        col_q, col_d;
  logic [CNT_BITS-1:0]           gt_q, gt_d;
  logic [CNT_BITS-1:0]           ge_q, ge_d;
  logic                          in_win;
  logic                          wrap;
  logic                          hit;

  assign in_win = int'(len_i) > INDEX;
  assign wrap   = int'(len_i) == INDEX + 1;
  // this cell holds the rank-th largest when fewer than rank values beat it
  // and at least rank values are no smaller
  assign hit    = in_win && (gt_q < rank_i) && (ge_q >= rank_i);

  always_comb begin
    value_d = value_q;
    rot_d   = rot_q;
    col_d   = col_q;
    gt_d    = gt_q;
    ge_d    = ge_q;
    if (cmd_i.shift) begin
      value_d = sample_i;
    end
    if (cmd_i.load) begin
      rot_d = value_q;
      gt_d  = '0;
      ge_d  = '0;
    end
    if (cmd_i.count) begin
      rot_d = wrap ? rot_wrap_i : rot_next_i;
      if (in_win) begin
        if (rot_q > value_q) begin
          gt_d = gt_q + 1'b1;
        end
        if (rot_q >= value_q) begin
          ge_d = ge_q + 1'b1;
        end
      end
    end
    if (cmd_i.mark) begin
      col_d = hit ? value_q : '0;
    end
    if (cmd_i.collect) begin
      col_d = col_q | col_next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    rot_q   <= rot_d;
    col_q   <= col_d;
    gt_q    <= gt_d;
    ge_q    <= ge_d;
  end

  assign value_o = value_q;
  assign rot_o   = rot_q;
  assign col_o   = col_q;
  assign hit_o   = hit;

endmodule
